// ----- design/rmlde_pkg.sv -----
// shared types and constants of the line drawing engine
package rmlde_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 128;
  localparam int PARAM_COUNT  = 29;
  localparam int REG_SPACE    = 32;
  localparam int PARAM_BASE   = 3;

  localparam int X_W    = 8;
  localparam int Y_W    = 7;
  localparam int ADDR_W = X_W + Y_W;
  localparam int PIX_W  = 4;
  localparam int PIDX_W = $clog2(PARAM_COUNT);

  localparam logic [7:0] REG_COMMAND = 8'd0;
  localparam logic [7:0] REG_FILL    = 8'd1;
  localparam logic [7:0] REG_OUTLINE = 8'd2;

  localparam logic [7:0] CMD_CLEAR    = 8'd0;
  localparam logic [7:0] CMD_PLOT     = 8'd1;
  localparam logic [7:0] CMD_LINE     = 8'd2;
  localparam logic [7:0] CMD_TRIANGLE = 8'd3;

  // endpoint pairs of a line
  localparam logic [1:0] SEL_AB = 2'd0;
  localparam logic [1:0] SEL_AC = 2'd1;
  localparam logic [1:0] SEL_CB = 2'd2;
  localparam logic [1:0] SEL_AA = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       is_read;
    logic       bad;
    logic       clear_start;
    logic       clear_step;
    logic       line_load;
    logic [1:0] line_sel;
    logic       line_step;
  } rmlde_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic line_last;
  } rmlde_stat_t;

endpackage

// ----- design/rmlde_ctrl.sv -----
// controller state machine of the line drawing engine
module rmlde_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  mode,
  input  logic [7:0]            reg_address,
  input  logic [7:0]            write_value,
  input  rmlde_pkg::rmlde_stat_t stat,
  output rmlde_pkg::rmlde_cmd_t  cmd,
  output logic                  busy,
  output logic                  done
);
  import rmlde_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_LSETUP = 3'd3;
  localparam logic [2:0] S_LSTEP  = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] sel, sel_next;
  logic       tri_mode, tri_mode_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESP);
  assign accept = start && !busy;

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    tri_mode_next = tri_mode;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.is_read   = mode;
    cmd.line_sel  = sel;
    case (state)
      S_INIT: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESP;
          if (!mode && reg_address == REG_COMMAND) begin
            case (write_value)
              CMD_CLEAR: begin
                cmd.clear_start = 1'b1;
                state_next      = S_CLEAR;
              end
              CMD_PLOT: begin
                sel_next      = SEL_AA;
                tri_mode_next = 1'b0;
                state_next    = S_LSETUP;
              end
              CMD_LINE: begin
                sel_next      = SEL_AB;
                tri_mode_next = 1'b0;
                state_next    = S_LSETUP;
              end
              CMD_TRIANGLE: begin
                sel_next      = SEL_AB;
                tri_mode_next = 1'b1;
                state_next    = S_LSETUP;
              end
              default: cmd.bad = 1'b1;
            endcase
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_RESP;
      end
      S_LSETUP: begin
        cmd.line_load = 1'b1;
        state_next    = S_LSTEP;
      end
      S_LSTEP: begin
        cmd.line_step = 1'b1;
        if (stat.line_last) begin
          if (tri_mode && sel != SEL_CB) begin
            sel_next   = (sel == SEL_AB) ? SEL_AC : SEL_CB;
            state_next = S_LSETUP;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sel      <= SEL_AB;
      tri_mode <= 1'b0;
    end else begin
      state    <= state_next;
      sel      <= sel_next;
      tri_mode <= tri_mode_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done) else $error("result strobe not followed by idle");
  a_no_dual_write: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !cmd.line_step) else $error("clear and line write together");
`endif

endmodule

// ----- design/rmlde_datapath.sv -----
// registers, line stepper, clear counter and frame store
module rmlde_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  rmlde_pkg::rmlde_cmd_t          cmd,
  input  logic [7:0]                     reg_address,
  input  logic [7:0]                     write_value,
  input  logic [rmlde_pkg::X_W-1:0]      read_x,
  input  logic [rmlde_pkg::Y_W-1:0]      read_y,
  output rmlde_pkg::rmlde_stat_t         stat,
  output logic [rmlde_pkg::PIX_W-1:0]    pixel_index,
  output logic                           bad_command
);
  import rmlde_pkg::*;

  logic [PIX_W-1:0]  mem [FRAME_WIDTH*FRAME_HEIGHT];
  logic [PIX_W-1:0]  rd_data;
  logic [7:0]        params [PARAM_COUNT];
  logic [PIX_W-1:0]  fill, outline, clr_color;
  logic [ADDR_W-1:0] clr_addr;
  logic              is_read_q, bad_q;
  logic              reg_wr;
  logic [7:0]        pofs;

  // line stepper
  logic [7:0]        x1, y1, x2, y2;
  logic [7:0]        dx, dy, ma0, na0, mb0, nb0;
  logic              steep0, swap;
  logic [7:0]        m, mb, q, span;
  logic signed [9:0] r, delta, r_sum;
  logic              steep;
  logic [7:0]        px, py;
  logic              line_we;

  assign reg_wr = cmd.accept && !cmd.is_read;
  assign pofs   = reg_address - 8'(PARAM_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      outline <= PIX_W'(1);
      for (int i = 0; i < PARAM_COUNT; i++) params[i] <= '0;
    end else if (reg_wr) begin
      if (reg_address == REG_FILL) fill <= write_value[PIX_W-1:0];
      else if (reg_address == REG_OUTLINE) outline <= write_value[PIX_W-1:0];
      else if (reg_address >= 8'(PARAM_BASE) && reg_address < 8'(REG_SPACE)
               && pofs < 8'(PARAM_COUNT))
        params[pofs[PIDX_W-1:0]] <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_read_q <= 1'b0;
      bad_q     <= 1'b0;
    end else if (cmd.accept) begin
      is_read_q <= cmd.is_read;
      bad_q     <= cmd.bad;
    end
  end

  assign pixel_index = is_read_q ? rd_data : '0;
  assign bad_command = bad_q;

  // clear sweep, the reset pass writes index 0
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      clr_color <= '0;
    end else if (cmd.clear_start) begin
      clr_addr  <= '0;
      clr_color <= fill;
    end else if (cmd.clear_step) begin
      clr_addr  <= clr_addr + 1'b1;
    end
  end
  assign stat.clear_last = (clr_addr == {ADDR_W{1'b1}});

  always_comb begin
    case (cmd.line_sel)
      SEL_AB:  begin x1 = params[0]; y1 = params[1]; x2 = params[2]; y2 = params[3]; end
      SEL_AC:  begin x1 = params[0]; y1 = params[1]; x2 = params[4]; y2 = params[5]; end
      SEL_CB:  begin x1 = params[4]; y1 = params[5]; x2 = params[2]; y2 = params[3]; end
      default: begin x1 = params[0]; y1 = params[1]; x2 = params[0]; y2 = params[1]; end
    endcase
    dx     = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy     = (y1 > y2) ? y1 - y2 : y2 - y1;
    steep0 = dy > dx;
    ma0    = steep0 ? y1 : x1;
    na0    = steep0 ? x1 : y1;
    mb0    = steep0 ? y2 : x2;
    nb0    = steep0 ? x2 : y2;
    swap   = ma0 > mb0;
  end

  // minor coordinate kept as quotient q and remainder r over span
  assign r_sum = r + delta;

  always_ff @(posedge clk) begin
    if (cmd.line_load) begin
      steep <= steep0;
      m     <= swap ? mb0 : ma0;
      mb    <= swap ? ma0 : mb0;
      q     <= swap ? nb0 : na0;
      span  <= swap ? ma0 - mb0 : mb0 - ma0;
      delta <= swap ? 10'($signed({2'b00, na0})) - 10'($signed({2'b00, nb0}))
                    : 10'($signed({2'b00, nb0})) - 10'($signed({2'b00, na0}));
      r     <= '0;
    end else if (cmd.line_step) begin
      m <= m + 1'b1;
      if (r_sum >= $signed({2'b00, span})) begin
        r <= r_sum - $signed({2'b00, span});
        q <= q + 1'b1;
      end else if (r_sum < 0) begin
        r <= r_sum + $signed({2'b00, span});
        q <= q - 1'b1;
      end else begin
        r <= r_sum;
      end
    end
  end
  assign stat.line_last = (m == mb);

  assign px      = steep ? q : m;
  assign py      = steep ? m : q;
  assign line_we = cmd.line_step && (py < 8'(FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (cmd.clear_step)
      mem[clr_addr] <= clr_color;
    else if (line_we)
      mem[{py[Y_W-1:0], px}] <= outline;
    if (cmd.accept && cmd.is_read)
      rd_data <= mem[{read_y, read_x}];
  end

endmodule

// ----- design/register_mapped_line_drawing_engine.sv -----
// top level of the register mapped line drawing engine
//
// one beat is accepted when start is high and busy is low. mode 0 is a
// register write (reg_address, write_value), mode 1 a pixel read at
// (read_x, read_y). every beat yields one result: done pulses for one cycle
// with pixel_index (read data, 0 for writes) and bad_command.
// reads and plain register writes show done in the cycle after accept.
// clear walks the 32768-entry frame store at one write a cycle. a line
// loads its endpoints in a setup state, then steps one pixel at a time
// along its major axis; a point is a one-pixel line, and a triangle draws
// lines AB, AC and CB in turn. the frame store has a single write port.
// one beat is in flight at a time; busy stays high until its result has
// been shown. after reset busy stays high while the frame store is
// swept to index 0; fill resets to 0, outline to 1, parameter bytes to 0.
// the receiver cannot stall: done is shown once and must be taken then.
module register_mapped_line_drawing_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [7:0]                    reg_address,
  input  logic [7:0]                    write_value,
  input  logic [rmlde_pkg::X_W-1:0]     read_x,
  input  logic [rmlde_pkg::Y_W-1:0]     read_y,
  output logic                          done,
  output logic [rmlde_pkg::PIX_W-1:0]   pixel_index,
  output logic                          bad_command
);
  import rmlde_pkg::*;

  rmlde_cmd_t  cmd;
  rmlde_stat_t stat;

  rmlde_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .reg_address (reg_address),
    .write_value (write_value),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done)
  );

  rmlde_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .reg_address (reg_address),
    .write_value (write_value),
    .read_x      (read_x),
    .read_y      (read_y),
    .stat        (stat),
    .pixel_index (pixel_index),
    .bad_command (bad_command)
  );

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench of the register mapped line drawing engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmlde_pkg::*;

  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic       mode;
    logic [7:0] addr;
    logic [7:0] val;
    logic [7:0] rx;
    logic [6:0] ry;
  } access_t;

  typedef struct {
    logic [3:0] pix;
    logic       bad;
  } reply_t;

  // directed row: access plus an optional typed-in answer
  typedef struct {
    access_t acc;
    logic    fixed;
    reply_t  ans;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic [7:0] reg_address = '0;
  logic [7:0] write_value = '0;
  logic [X_W-1:0] read_x = '0;
  logic [Y_W-1:0] read_y = '0;
  logic done;
  logic [PIX_W-1:0] pixel_index;
  logic bad_command;

  logic [3:0] shadow_frame [FRAME_WIDTH*FRAME_HEIGHT];
  logic [7:0] shadow_param [PARAM_COUNT];
  logic [3:0] shadow_fill;
  logic [3:0] shadow_outline;

  reply_t pending_replies[$];
  int     errors = 0;
  int     quiet_cycles = 0;
  int     send_idle_pct = 10;

  register_mapped_line_drawing_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .reg_address(reg_address), .write_value(write_value), .read_x(read_x),
    .read_y(read_y), .done(done), .pixel_index(pixel_index),
    .bad_command(bad_command)
  );

  always #10 clk = ~clk;

  function automatic void shadow_plot(int x, int y);
    if (x < FRAME_WIDTH && y < FRAME_HEIGHT) shadow_frame[y*FRAME_WIDTH + x] = shadow_outline;
  endfunction

  function automatic void shadow_line(int x1, int y1, int x2, int y2);
    int dx, dy, ma, mb, na, nb, t, n;
    bit steep;
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    steep = dy > dx;
    ma = steep ? y1 : x1;  na = steep ? x1 : y1;
    mb = steep ? y2 : x2;  nb = steep ? x2 : y2;
    if (ma > mb) begin
      t = ma; ma = mb; mb = t;
      t = na; na = nb; nb = t;
    end
    if (mb == ma) begin
      shadow_plot(x1, y1);
      return;
    end
    for (int m = ma; m <= mb; m++) begin
      n = (na*(mb - m) + nb*(m - ma)) / (mb - ma);
      if (steep) shadow_plot(n, m);
      else shadow_plot(m, n);
    end
  endfunction

  function automatic reply_t predict_access(access_t a);
    reply_t r;
    int p0, p1, p2, p3, p4, p5;
    r.pix = '0;
    r.bad = 1'b0;
    p0 = shadow_param[0]; p1 = shadow_param[1]; p2 = shadow_param[2];
    p3 = shadow_param[3]; p4 = shadow_param[4]; p5 = shadow_param[5];
    if (a.mode) begin
      r.pix = shadow_frame[int'(a.ry)*FRAME_WIDTH + int'(a.rx)];
    end else if (a.addr == REG_COMMAND) begin
      case (a.val)
        CMD_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = shadow_fill;
        CMD_PLOT: shadow_plot(p0, p1);
        CMD_LINE: shadow_line(p0, p1, p2, p3);
        CMD_TRIANGLE: begin
          shadow_line(p0, p1, p2, p3);
          shadow_line(p0, p1, p4, p5);
          shadow_line(p4, p5, p2, p3);
        end
        default: r.bad = 1'b1;
      endcase
    end else if (a.addr == REG_FILL) begin
      shadow_fill = a.val[3:0];
    end else if (a.addr == REG_OUTLINE) begin
      shadow_outline = a.val[3:0];
    end else if (a.addr < REG_SPACE && a.addr - PARAM_BASE < PARAM_COUNT) begin
      shadow_param[a.addr - PARAM_BASE] = a.val;
    end
    return r;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (done) begin
        if (pending_replies.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (pixel_index !== want.pix) begin
            $error("pixel_index expected %0d got %0d", want.pix, pixel_index);
            errors++;
          end
          if (bad_command !== want.bad) begin
            $error("bad_command expected %0d got %0d", want.bad, bad_command);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_access(access_t a, bit fixed = 1'b0, reply_t ans = '{4'd0, 1'b0});
    reply_t r;
    // start was dropped at the previous falling edge, so drive it again at a later falling edge
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    mode <= a.mode; reg_address <= a.addr; write_value <= a.val;
    read_x <= a.rx; read_y <= a.ry; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_access(a);
    if (fixed) begin
      if (r.pix !== ans.pix || r.bad !== ans.bad) begin
        $error("directed row: predictor pix %0d bad %0d, table pix %0d bad %0d",
               r.pix, r.bad, ans.pix, ans.bad);
        errors++;
      end
      r = ans;
    end
    pending_replies.push_back(r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic access_t wr(logic [7:0] addr, logic [7:0] val);
    return '{1'b0, addr, val, 8'd0, 7'd0};
  endfunction

  function automatic access_t rd(logic [7:0] x, logic [6:0] y);
    return '{1'b1, 8'd0, 8'd0, x, y};
  endfunction

  task automatic drain();
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic random_shape();
    access_t a;
    int kind;
    kind = $urandom_range(3, 1);
    // params: mostly small coordinates, sometimes the full byte range
    for (int k = 0; k < 2*kind; k++) begin
      send_access(wr(8'(PARAM_BASE + k), ($urandom_range(3) == 0) ? 8'($urandom) :
                     8'($urandom_range(40))));
    end
    if ($urandom_range(3) == 0) send_access(wr(REG_OUTLINE, 8'($urandom)));
    send_access(wr(REG_COMMAND, 8'(kind)));
    for (int k = 0; k < 3; k++) begin
      a = rd(8'($urandom_range(40)), 7'($urandom_range(40)));
      if ($urandom_range(1)) a = rd(8'($urandom), 7'($urandom));
      send_access(a);
    end
  endtask

  row_t directed[] = '{
    '{rd(8'd0, 7'd0), 1'b1, '{4'd0, 1'b0}},
    '{rd(8'd255, 7'd127), 1'b1, '{4'd0, 1'b0}},
    '{wr(8'd3, 8'd255), 1'b1, '{4'd0, 1'b0}},
    '{wr(8'd4, 8'd127), 1'b1, '{4'd0, 1'b0}},
    '{wr(REG_COMMAND, CMD_PLOT), 1'b1, '{4'd0, 1'b0}},
    '{rd(8'd255, 7'd127), 1'b1, '{4'd1, 1'b0}},
    '{wr(8'd4, 8'd200), 1'b0, '{4'd0, 1'b0}},
    '{wr(REG_COMMAND, CMD_PLOT), 1'b0, '{4'd0, 1'b0}},
    '{wr(REG_OUTLINE, 8'hfa), 1'b1, '{4'd0, 1'b0}},
    '{wr(8'd3, 8'd0), 1'b0, '{4'd0, 1'b0}},
    '{wr(8'd4, 8'd0), 1'b0, '{4'd0, 1'b0}},
    '{wr(8'd5, 8'd255), 1'b0, '{4'd0, 1'b0}},
    '{wr(8'd6, 8'd127), 1'b0, '{4'd0, 1'b0}},
    '{wr(REG_COMMAND, CMD_LINE), 1'b0, '{4'd0, 1'b0}},
    '{rd(8'd128, 7'd63), 1'b0, '{4'd0, 1'b0}},
    '{wr(8'd7, 8'd10), 1'b0, '{4'd0, 1'b0}},
    '{wr(8'd8, 8'd255), 1'b0, '{4'd0, 1'b0}},
    '{wr(REG_COMMAND, CMD_TRIANGLE), 1'b0, '{4'd0, 1'b0}},
    '{rd(8'd5, 7'd5), 1'b0, '{4'd0, 1'b0}},
    '{wr(8'd31, 8'hff), 1'b1, '{4'd0, 1'b0}},
    '{wr(8'd255, 8'hff), 1'b1, '{4'd0, 1'b0}},
    '{wr(REG_COMMAND, 8'd4), 1'b1, '{4'd0, 1'b1}},
    '{wr(REG_COMMAND, 8'd255), 1'b1, '{4'd0, 1'b1}},
    '{wr(REG_FILL, 8'hf7), 1'b1, '{4'd0, 1'b0}},
    '{wr(REG_COMMAND, CMD_CLEAR), 1'b1, '{4'd0, 1'b0}}
  };

  initial begin
    access_t a;
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    foreach (shadow_param[i]) shadow_param[i] = '0;
    shadow_fill = '0;
    shadow_outline = 4'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_access(directed[i].acc, directed[i].fixed, directed[i].ans);
    send_access(rd(8'd77, 7'd99), 1'b1, '{4'd7, 1'b0});
    // hold off until the engine has answered everything
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 82 : 0;
      for (int s = 0; s < 3; s++) random_shape();
      // noise: any field value, rarely a clear since it is slow
      for (int n = 0; n < 4; n++) begin
        a = '{1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom)};
        if (a.mode == 1'b0 && $urandom_range(1)) a.addr = 8'($urandom_range(2));
        if (a.mode == 1'b0 && a.addr == REG_COMMAND && a.val == CMD_CLEAR
            && $urandom_range(3) != 0) a.val = 8'd4;
        send_access(a);
      end
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
